FILE: rtl/sal_pkg.sv
// Shared types and constants for the sorted array list.
package sal_pkg;

    // Default sizes of the list store
    localparam int CAPACITY_DEF    = 16;
    localparam int VALUE_WIDTH_DEF = 8;

    // Field widths on the streaming ports
    localparam int CMD_W     = 2;
    localparam int VAL_IN_W  = 8;
    localparam int STATUS_W  = 2;
    localparam int POS_W     = 5;
    localparam int COUNT_W   = 5;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 16;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT,
        CMD_REMOVE,
        CMD_FIND,
        CMD_IGNORE
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_DONE,
        STAT_FULL,
        STAT_EMPTY,
        STAT_NOT_FOUND
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_CMP,
        ST_INS_WR,
        ST_BS_RD,
        ST_BS_CMP,
        ST_RM_SH,
        ST_DONE
    } state_t;

endpackage

FILE: rtl/sal_ram.sv
// Single-port-write, single-port-read synchronous RAM holding the list entries.
module sal_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8,
    parameter int AW    = 4
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/sorted_array_list_top.sv
// Sorted array list: ascending store with insert, remove and binary-search find.
// Refusals and ignored commands go straight to the result; insert shifts larger entries up
// from the top entry down, then writes the key; find runs binary-search probes; remove runs
// the probes and, if the key is found, shifts each later entry down by one.
// One item is handled at a time; the next input
// transfer is taken the cycle after the result is registered. Reset clears FSM, occupancy, valid.
module sorted_array_list_top #(
    parameter int CAPACITY    = sal_pkg::CAPACITY_DEF,
    parameter int VALUE_WIDTH = sal_pkg::VALUE_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // s_tdata: [1:0] command, [9:2] value, [15:10] zero
    input  logic [sal_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // m_tdata: [1:0] status, [6:2] position, [11:7] entry_count,
    //          [12] full flag, [13] empty flag, [15:14] zero
    output logic [sal_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready
);

    import sal_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    state_t                  state_reg, state_next;
    logic [CW-1:0]           occ_reg, occ_next;
    logic [CW-1:0]           idx_reg, idx_next;
    logic [CW-1:0]           lo_reg, lo_next;
    logic [CW-1:0]           hip1_reg, hip1_next;
    logic [CW-1:0]           pos_reg, pos_next;
    logic [VALUE_WIDTH-1:0]  key_reg, key_next;
    cmd_t                    cmd_reg, cmd_next;
    status_t                 status_reg, status_next;
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]    m_tdata_reg, m_tdata_next;

    logic                    ram_we;
    logic [AW-1:0]           ram_waddr;
    logic [VALUE_WIDTH-1:0]  ram_wdata;
    logic                    ram_re;
    logic [AW-1:0]           ram_raddr;
    logic [VALUE_WIDTH-1:0]  ram_rdata;

    logic [CW-1:0]           occ_m1;
    logic [CW-1:0]           idx_inc;
    logic [CW-1:0]           idx_dec;
    logic [CW:0]             mid_sum;
    logic                    in_cmd_ok;
    cmd_t                    in_cmd;

    assign occ_m1  = occ_reg - CW'(1);
    assign idx_inc = idx_reg + CW'(1);
    assign idx_dec = idx_reg - CW'(1);
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hip1_reg} - (CW+1)'(1);
    assign in_cmd  = cmd_t'(s_tdata[CMD_W-1:0]);
    assign in_cmd_ok = (occ_reg != '0);

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    sal_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (VALUE_WIDTH),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Sequence the search, shift and result steps
    always_comb
    begin
        state_next    = state_reg;
        occ_next      = occ_reg;
        idx_next      = idx_reg;
        lo_next       = lo_reg;
        hip1_next     = hip1_reg;
        pos_next      = pos_reg;
        key_next      = key_reg;
        cmd_next      = cmd_reg;
        status_next   = status_reg;
        ram_we        = 1'b0;
        ram_waddr     = idx_reg[AW-1:0];
        ram_wdata     = ram_rdata;
        ram_re        = 1'b0;
        ram_raddr     = idx_reg[AW-1:0];
        m_tvalid_next = m_tvalid_reg & ~m_tready;
        m_tdata_next  = m_tdata_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    key_next    = VALUE_WIDTH'(s_tdata[CMD_W +: VAL_IN_W]);
                    cmd_next    = in_cmd;
                    pos_next    = '0;
                    status_next = STAT_DONE;
                    lo_next     = '0;
                    hip1_next   = occ_reg;
                    state_next  = ST_DONE;
                    case (in_cmd)
                        CMD_INSERT:
                        begin
                            if (occ_reg == CAP_C)
                            begin
                                status_next = STAT_FULL;
                            end
                            else if (!in_cmd_ok)
                            begin
                                state_next = ST_INS_WR;
                            end
                            else
                            begin
                                // Start the shift scan at the top entry
                                idx_next   = occ_m1;
                                ram_re     = 1'b1;
                                ram_raddr  = occ_m1[AW-1:0];
                                state_next = ST_INS_CMP;
                            end
                        end
                        CMD_REMOVE:
                        begin
                            if (!in_cmd_ok)
                            begin
                                status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                state_next = ST_BS_RD;
                            end
                        end
                        CMD_FIND:
                        begin
                            if (!in_cmd_ok)
                            begin
                                status_next = STAT_NOT_FOUND;
                            end
                            else
                            begin
                                state_next = ST_BS_RD;
                            end
                        end
                        default:
                        begin
                            status_next = STAT_DONE;
                        end
                    endcase
                end
            end

            // Move entries greater than the key up by one, top down
            ST_INS_CMP:
            begin
                if (ram_rdata > key_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = idx_inc[AW-1:0];
                    ram_wdata = ram_rdata;
                    if (idx_reg == '0)
                    begin
                        pos_next   = '0;
                        state_next = ST_INS_WR;
                    end
                    else
                    begin
                        idx_next  = idx_dec;
                        ram_re    = 1'b1;
                        ram_raddr = idx_dec[AW-1:0];
                    end
                end
                else
                begin
                    pos_next   = idx_inc;
                    state_next = ST_INS_WR;
                end
            end

            // Drop the key into the freed slot
            ST_INS_WR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = pos_reg[AW-1:0];
                ram_wdata  = key_reg;
                occ_next   = occ_reg + CW'(1);
                state_next = ST_DONE;
            end

            // Issue the next binary-search probe
            ST_BS_RD:
            begin
                if (lo_reg < hip1_reg)
                begin
                    idx_next   = mid_sum[CW:1];
                    ram_re     = 1'b1;
                    ram_raddr  = mid_sum[AW:1];
                    state_next = ST_BS_CMP;
                end
                else
                begin
                    status_next = STAT_NOT_FOUND;
                    state_next  = ST_DONE;
                end
            end

            // Compare the probed entry and narrow the window
            ST_BS_CMP:
            begin
                if (ram_rdata == key_reg)
                begin
                    pos_next   = idx_reg;
                    state_next = ST_DONE;
                    if (cmd_reg == CMD_REMOVE)
                    begin
                        if (idx_inc < occ_reg)
                        begin
                            idx_next   = idx_inc;
                            ram_re     = 1'b1;
                            ram_raddr  = idx_inc[AW-1:0];
                            state_next = ST_RM_SH;
                        end
                        else
                        begin
                            occ_next = occ_m1;
                        end
                    end
                end
                else if (ram_rdata > key_reg)
                begin
                    hip1_next  = idx_reg;
                    state_next = ST_BS_RD;
                end
                else
                begin
                    lo_next    = idx_inc;
                    state_next = ST_BS_RD;
                end
            end

            // Close the gap, moving each later entry down by one
            ST_RM_SH:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_dec[AW-1:0];
                ram_wdata = ram_rdata;
                if (idx_inc < occ_reg)
                begin
                    idx_next  = idx_inc;
                    ram_re    = 1'b1;
                    ram_raddr = idx_inc[AW-1:0];
                end
                else
                begin
                    occ_next   = occ_m1;
                    state_next = ST_DONE;
                end
            end

            // Hand the result to the output register once it is free
            ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {2'b00,
                                     (occ_reg == '0),
                                     (occ_reg == CAP_C),
                                     COUNT_W'(occ_reg),
                                     POS_W'(pos_reg),
                                     status_reg};
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            occ_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            occ_reg      <= occ_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Working and payload registers
    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        lo_reg      <= lo_next;
        hip1_reg    <= hip1_next;
        pos_reg     <= pos_next;
        key_reg     <= key_next;
        cmd_reg     <= cmd_next;
        status_reg  <= status_next;
        m_tdata_reg <= m_tdata_next;
    end

endmodule
